/* design/rsmst_pkg.sv */
// ----------------------------------------------------------------------------
// rsmst_pkg: shared types and codes for the range second-minimum core
// Opcodes, status codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package rsmst_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned BOUND_W = 11;
  localparam int unsigned STAT_W  = 2;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_BUILT = 2'd1;
  localparam logic [STAT_W-1:0] ST_ERR   = 2'd2;

  // classified command handed to the back end
  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_BUILD,
    CMD_QUERY,
    CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic signed [VAL_W-1:0]  value;
    logic [BOUND_W-1:0]       lo;   // 0-based, lo < hi for a query
    logic [BOUND_W-1:0]       hi;
  } cmd_t;

endpackage

/* design/rsmst_front.sv */
// ----------------------------------------------------------------------------
// rsmst_front: input acceptance and classification
// Orders query bounds, tracks fill and build state, queues commands.
// ----------------------------------------------------------------------------
module rsmst_front #(
  parameter int unsigned CNT_W = 11,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [rsmst_pkg::OP_W-1:0]   in_opcode,
  input  logic signed [rsmst_pkg::VAL_W-1:0] in_load_value,
  input  logic [rsmst_pkg::BOUND_W-1:0] in_range_left,
  input  logic [rsmst_pkg::BOUND_W-1:0] in_range_right,
  output logic                         q_valid,
  output rsmst_pkg::cmd_t              q_cmd,
  input  logic                         q_take
);
  import rsmst_pkg::*;

  localparam int unsigned QD = 2;

  logic [CNT_W-1:0] count_r;
  logic             ready_r;
  cmd_t             qmem_r [QD];
  logic             wp_r, rp_r;
  logic [1:0]       fill_r;
  logic             push;
  cmd_t             cmd;
  logic [BOUND_W-1:0] lo, hi;
  logic             bad;

  assign in_stall = (fill_r == 2'(QD));
  wire accept = in_valid && !in_stall;

  // order bounds and classify
  always_comb begin
    lo  = (in_range_left > in_range_right) ? in_range_right : in_range_left;
    hi  = (in_range_left > in_range_right) ? in_range_left : in_range_right;
    bad = !ready_r || lo == '0 || {{(32-BOUND_W){1'b0}}, hi} > 32'(count_r) || lo == hi;
    cmd.value = in_load_value;
    cmd.lo    = lo - 1'b1;
    cmd.hi    = hi - 1'b1;
    cmd.kind  = CMD_ERROR;
    push      = 1'b0;
    unique case (in_opcode)
      OP_LOAD: begin
        cmd.kind = CMD_LOAD;
        push     = 32'(count_r) < DEPTH;
      end
      OP_BUILD: begin
        cmd.kind = CMD_BUILD;
        push     = 1'b1;
      end
      OP_QUERY: begin
        cmd.kind = bad ? CMD_ERROR : CMD_QUERY;
        push     = 1'b1;
      end
      default: push = 1'b0;
    endcase
    push = push && accept;
  end

  // track fill and build state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ready_r <= 1'b0;
    end else if (accept) begin
      if (in_opcode == OP_LOAD && 32'(count_r) < DEPTH) begin
        count_r <= count_r + 1'b1;
        ready_r <= 1'b0;
      end else if (in_opcode == OP_BUILD) begin
        ready_r <= 1'b1;
      end
    end
  end

  // command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_take) rp_r <= ~rp_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, q_take};
    end
  end

  always_ff @(posedge clk) begin
    if (push) qmem_r[wp_r] <= cmd;
  end

  assign q_valid = (fill_r != '0);
  assign q_cmd   = qmem_r[rp_r];

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> fill_r != 2'(QD)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> q_valid) else $error("queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH) else $error("count beyond depth");
`endif
endmodule

/* design/rsmst_back.sv */
// ----------------------------------------------------------------------------
// rsmst_back: value store, table build walk and query sequencer
// Build merges one entry at a time; a query reads two entries and values.
// ----------------------------------------------------------------------------
module rsmst_back #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned LEVELS = 11,
  parameter int unsigned AW     = 10,
  parameter int unsigned LW     = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  rsmst_pkg::cmd_t              q_cmd,
  output logic                         q_take,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [rsmst_pkg::VAL_W-1:0] out_answer_value,
  output logic [rsmst_pkg::STAT_W-1:0] out_status
);
  import rsmst_pkg::*;

  localparam int unsigned TD = LEVELS * DEPTH;
  localparam int unsigned TW = $clog2(TD);

  typedef struct packed {
    logic [AW-1:0] first;
    logic [AW-1:0] second;
    logic          has2;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_B0, S_BRD, S_BV0, S_BV1, S_BWR, S_BMG,
    S_QRD, S_QV0, S_QV1, S_QANS, S_OUT
  } state_t;

  logic signed [VAL_W-1:0] vmem [DEPTH];
  ent_t                    tmem [TD];

  state_t            state_r;
  logic [AW:0]       n_r;        // loaded count
  logic [LW-1:0]     lvl_r;
  logic [AW:0]       idx_r;
  logic [AW-1:0]     lo_r, hi_r;
  ent_t              m_r;
  logic [AW-1:0]     cand_r [4];
  logic              cv_r [4];
  logic signed [VAL_W-1:0] cval_r [4];
  logic [1:0]        ci_r;
  logic [AW-1:0]     vaddr;
  logic signed [VAL_W-1:0] vrd_r;
  logic [TW-1:0]     ta0, ta1;
  ent_t              trd0_r, trd1_r;
  logic              twe;
  logic [TW-1:0]     twa;
  ent_t              twd;
  logic signed [VAL_W-1:0] ans_r;
  logic [STAT_W-1:0] st_r;
  logic [LW-1:0]     qk;
  logic [AW:0]       len;

  function automatic logic [LW-1:0] flog2(input logic [AW:0] v);
    logic [LW-1:0] k;
    k = '0;
    for (int i = 1; i <= AW; i++)
      if (v[i]) k = LW'(i);
    return k;
  endfunction

  function automatic logic ranks_first(input logic signed [VAL_W-1:0] va,
                                       input logic [AW-1:0] a,
                                       input logic signed [VAL_W-1:0] vb,
                                       input logic [AW-1:0] b);
    return (va != vb) ? (va < vb) : (a < b);
  endfunction

  // merge from registered candidates
  ent_t mrg;
  always_comb begin
    logic [1:0] f;
    logic       found;
    logic [1:0] s;
    f = 2'd0;
    for (int i = 1; i < 4; i++)
      if (cv_r[i] && ranks_first(cval_r[i], cand_r[i], cval_r[f], cand_r[f])) f = 2'(i);
    found = 1'b0;
    s = 2'd0;
    for (int i = 0; i < 4; i++)
      if (cv_r[i] && cand_r[i] != cand_r[f] &&
          (!found || ranks_first(cval_r[i], cand_r[i], cval_r[s], cand_r[s]))) begin
        s = 2'(i);
        found = 1'b1;
      end
    mrg.first  = cand_r[f];
    mrg.second = found ? cand_r[s] : '0;
    mrg.has2   = found;
  end

  assign len = {1'b0, hi_r} - {1'b0, lo_r} + 1'b1;
  always_comb begin
    qk = flog2(len);
    if (32'(qk) >= LEVELS) qk = LW'(LEVELS - 1);
  end

  // address selection
  always_comb begin
    logic [AW:0] half;
    half = (AW+1)'(1) << (lvl_r - 1'b1);
    ta0  = TW'(32'(lvl_r - 1'b1) * DEPTH + 32'(idx_r));
    ta1  = TW'(32'(lvl_r - 1'b1) * DEPTH + 32'(idx_r + half));
    if (state_r == S_QRD) begin
      ta0 = TW'(32'(qk) * DEPTH + 32'(lo_r));
      ta1 = TW'(32'(qk) * DEPTH + 32'(hi_r) + 1 - (32'(1) << qk));
    end
    vaddr = cand_r[ci_r];
    if (state_r == S_QANS) vaddr = m_r.second;
    twe = 1'b0;
    twa = TW'(32'(lvl_r) * DEPTH + 32'(idx_r));
    twd = mrg;
    if (state_r == S_B0) begin
      twe = 1'b1;
      twd = '{first: idx_r[AW-1:0], second: '0, has2: 1'b0};
    end else if (state_r == S_BMG) begin
      twe = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid && q_cmd.kind == CMD_LOAD)
      vmem[n_r[AW-1:0]] <= q_cmd.value;
    vrd_r <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (twe) tmem[twa] <= twd;
    trd0_r <= tmem[ta0];
    trd1_r <= tmem[ta1];
  end

  assign q_take = (state_r == S_IDLE) && q_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      n_r       <= '0;
      out_valid <= 1'b0;
      ci_r      <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          lo_r <= q_cmd.lo[AW-1:0];
          hi_r <= q_cmd.hi[AW-1:0];
          unique case (q_cmd.kind)
            CMD_LOAD: n_r <= n_r + 1'b1;
            CMD_BUILD: begin
              idx_r   <= '0;
              lvl_r   <= '0;
              state_r <= (n_r == '0) ? S_OUT : S_B0;
              ans_r   <= '0;
              st_r    <= ST_BUILT;
              out_valid <= (n_r == '0);
            end
            CMD_QUERY: state_r <= S_QRD;
            CMD_ERROR: begin
              ans_r <= '0;
              st_r  <= ST_ERR;
              out_valid <= 1'b1;
              state_r <= S_OUT;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        // level zero: one entry per cycle
        S_B0: begin
          if (idx_r + 1'b1 == n_r) begin
            idx_r <= '0;
            lvl_r <= LW'(1);
            if (n_r < (AW+1)'(2) || LEVELS < 2) begin
              out_valid <= 1'b1;
              state_r <= S_OUT;
            end else state_r <= S_BRD;
          end else idx_r <= idx_r + 1'b1;
        end
        S_BRD, S_QRD: begin
          state_r <= (state_r == S_BRD) ? S_BV0 : S_QV0;
          ci_r    <= '0;
        end
        S_BV0, S_QV0: begin
          cand_r[0] <= trd0_r.first;  cv_r[0] <= 1'b1;
          cand_r[1] <= trd0_r.second; cv_r[1] <= trd0_r.has2;
          cand_r[2] <= trd1_r.first;  cv_r[2] <= 1'b1;
          cand_r[3] <= trd1_r.second; cv_r[3] <= trd1_r.has2;
          ci_r    <= '0;
          state_r <= (state_r == S_BV0) ? S_BV1 : S_QV1;
        end
        // fetch four candidate values, one per cycle; the value-store read is registered
        S_BV1, S_QV1: begin
          ci_r <= ci_r + 1'b1;
          if (ci_r != '0) cval_r[ci_r - 1'b1] <= vrd_r;
          if (ci_r == 2'd3) state_r <= (state_r == S_BV1) ? S_BWR : S_QANS;
        end
        S_BWR: begin
          // last value arrives here
          cval_r[3] <= vrd_r;
          state_r <= S_BMG;
        end
        // write the merged entry, then advance index or level, or finish the build
        S_BMG: begin
          if (32'(idx_r) + 32'd1 + (32'd1 << lvl_r) <= 32'(n_r)) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_BRD;
          end else if (32'(lvl_r) + 32'd1 < LEVELS && (32'd2 << lvl_r) <= 32'(n_r)) begin
            idx_r   <= '0;
            lvl_r   <= lvl_r + 1'b1;
            state_r <= S_BRD;
          end else begin
            out_valid <= 1'b1;
            state_r   <= S_OUT;
          end
        end
        S_QANS: begin
          cval_r[3] <= vrd_r;
          state_r   <= S_QANS;
          if (ci_r == 2'd0) begin
            ci_r <= 2'd1;
          end else if (ci_r == 2'd1) begin
            m_r  <= mrg;
            ci_r <= 2'd2;
          end else if (ci_r == 2'd2) begin
            ci_r <= 2'd3;
          end else begin
            ans_r <= m_r.has2 ? vrd_r : '0;
            st_r  <= m_r.has2 ? ST_OK : ST_ERR;
            out_valid <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_OUT: if (!out_stall) begin
          out_valid <= 1'b0;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_answer_value = ans_r;
  assign out_status       = st_r;

`ifndef ASSERT_OFF
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_take |-> !out_valid) else $error("take while result pending");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(n_r) <= DEPTH) else $error("store overfilled");
`endif
endmodule

/* design/range_second_minimum_sparse_table_core.sv */
// A load is queued on accept and stored once the sequencer takes it; a query
// steps through S_QRD, S_QV0, S_QV1, S_QANS and S_OUT; a build fills level
// zero in S_B0, then merges each entry of each level via S_BRD, S_BV0, S_BV1,
// S_BWR and S_BMG. One command at a time: table and value reads are serial.
// Reset (rst_n low, synchronous) clears counts, queue, built flag and state;
// the value store and window table hold nothing defined until written.
// ----------------------------------------------------------------------------
// range_second_minimum_sparse_table_core: top level
// Front classifier and command queue feeding the table engine.
// ----------------------------------------------------------------------------
module range_second_minimum_sparse_table_core #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned MAX_LEVELS   = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rsmst_pkg::OP_W-1:0]          in_opcode,
  input  logic signed [rsmst_pkg::VAL_W-1:0]  in_load_value,
  input  logic [rsmst_pkg::BOUND_W-1:0]       in_range_left,
  input  logic [rsmst_pkg::BOUND_W-1:0]       in_range_right,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rsmst_pkg::VAL_W-1:0]  out_answer_value,
  output logic [rsmst_pkg::STAT_W-1:0]        out_status
);
  import rsmst_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned LW = $clog2(MAX_LEVELS + 1);

  logic q_valid, q_take;
  cmd_t q_cmd;

  rsmst_front #(.CNT_W(AW + 1), .DEPTH(MAX_ELEMENTS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_opcode, .in_load_value,
    .in_range_left, .in_range_right, .q_valid, .q_cmd, .q_take
  );

  rsmst_back #(.DEPTH(MAX_ELEMENTS), .LEVELS(MAX_LEVELS), .AW(AW), .LW(LW)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_take, .out_valid, .out_stall,
    .out_answer_value, .out_status
  );
endmodule
